>>> src/crcd_pkg.sv
// Shared types and sizes for the clock-replacement key directory.
// No dependencies; used by crcd_cell and clock_replacement_cache_dir.
`default_nettype none

package crcd_pkg;

  localparam int SLOTS    = 16;
  localparam int KEY_BITS = 32;
  localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CAP_W    = 5;
  localparam int FIELD_W  = 32;
  localparam int SLOT_W   = 4;
  localparam int OUT_W    = 72;

  // request modes carried on in_tuser
  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_PUT = 1'b1;

  // probe travelling down the row of cells
  typedef struct packed {
    logic                valid;
    logic                found;
    logic [IDX_W-1:0]    idx;
    logic [KEY_BITS-1:0] key;
  } crcd_probe_t;

  // update broadcast from the controller to all cells; the cell at idx acts on it
  typedef struct packed {
    logic                wr;
    logic                set_ref;
    logic                clr_ref;
    logic [IDX_W-1:0]    idx;
    logic [KEY_BITS-1:0] key;
  } crcd_cmd_t;

endpackage

`default_nettype wire

>>> src/clock_replacement_cache_dir.sv
// Clock (second-chance) key directory: top level with controller and the row
// of slot cells. Depends on crcd_pkg and crcd_cell.
//
// Usage:
//   in_*  : one item per request. in_tuser = mode (0 get, 1 put),
//           in_tdata = key. Accepted when in_tvalid and in_tready are high.
//   out_* : one result item per request, held in an output register until
//           out_tready; in_tready drops while an item is in progress.
//   cfg_* : cfg_wr_en writes capacity (slots taking part in fill and sweep);
//           0 acts as 1, values above the slot count saturate.
// Flow: the key walks the row of cells one slot per cycle, from the launch
// register through each cell's probe register, and the lookup decides when it
// leaves the last cell; get, touch and fill then go through the finish state
// into the output register. A replacement adds the hand sweep, one slot per
// cycle, before the finish state. One item is in flight.
// Reset (rst_n low, synchronous) empties the directory, clears reference
// bits, hand and fill count, and sets capacity to the slot count.
// A stalled receiver holds the result; a later result waits in the finish state.
`default_nettype none

module clock_replacement_cache_dir (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_tvalid,
  output logic                         in_tready,
  input  wire  [31:0]                  in_tdata,   // [31:0] key
  input  wire                          in_tuser,   // [0] mode
  output logic                         out_tvalid,
  input  wire                          out_tready,
  // [0] hit, [32:1] value, [33] evicted, [65:34] evicted_key, [69:66] slot
  output logic [crcd_pkg::OUT_W-1:0]   out_tdata,
  input  wire                          cfg_wr_en,
  input  wire  [crcd_pkg::CAP_W-1:0]   cfg_wr_data
);

  localparam int SLOTS = crcd_pkg::SLOTS;
  localparam int IDX_W = crcd_pkg::IDX_W;
  localparam int CAP_W = crcd_pkg::CAP_W;
  localparam int KW    = crcd_pkg::KEY_BITS;
  localparam int FW    = crcd_pkg::FIELD_W;

  typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_SWEEP, S_FINISH} state_t;

  state_t                  state_r;
  logic [CAP_W-1:0]        cap_r;
  logic [CAP_W-1:0]        live_cap;
  logic [CAP_W-1:0]        fill_r;
  logic [IDX_W-1:0]        hand_r;
  logic [IDX_W-1:0]        hand_inc;
  logic                    mode_r;
  logic [KW-1:0]           key_r;
  logic                    res_hit_r;
  logic [FW-1:0]           res_value_r;
  logic                    res_evicted_r;
  logic [FW-1:0]           res_ekey_r;
  logic [crcd_pkg::SLOT_W-1:0] res_slot_r;
  logic                    out_tvalid_r;
  logic [crcd_pkg::OUT_W-1:0] out_tdata_r;

  crcd_pkg::crcd_probe_t   launch_r;
  crcd_pkg::crcd_probe_t   chain [SLOTS+1];
  crcd_pkg::crcd_probe_t   tail;
  crcd_pkg::crcd_cmd_t     cmd;
  logic [SLOTS-1:0]        occ_vec;
  logic [SLOTS-1:0]        ref_vec;
  logic [KW-1:0]           keys [SLOTS];
  logic                    in_acc;
  logic                    hand_free;

  assign chain[0] = launch_r;
  assign tail     = chain[SLOTS];

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    crcd_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .slot_id   (IDX_W'(g)),
      .probe_in  (chain[g]),
      .probe_out (chain[g+1]),
      .cmd       (cmd),
      .occ       (occ_vec[g]),
      .refb      (ref_vec[g]),
      .key       (keys[g])
    );
  end

  always_comb begin
    if (cap_r == '0) begin
      live_cap = CAP_W'(1);
    end else if (cap_r > CAP_W'(SLOTS)) begin
      live_cap = CAP_W'(SLOTS);
    end else begin
      live_cap = cap_r;
    end
  end

  assign in_tready = rst_n & (state_r == S_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign hand_inc  = ((CAP_W'(hand_r) + CAP_W'(1)) == live_cap) ? '0 : hand_r + IDX_W'(1);
  assign hand_free = ~occ_vec[hand_r] | ~ref_vec[hand_r];

  always_comb begin
    cmd = '0;
    case (state_r)
      S_SEARCH: begin
        if (tail.valid) begin
          if (tail.found) begin
            cmd.set_ref = 1'b1;
            cmd.idx     = tail.idx;
          end else if ((mode_r == crcd_pkg::MODE_PUT) && (fill_r < live_cap)) begin
            cmd.wr  = 1'b1;
            cmd.idx = fill_r[IDX_W-1:0];
            cmd.key = key_r;
          end
        end
      end
      S_SWEEP: begin
        cmd.idx = hand_r;
        cmd.key = key_r;
        if (hand_free) begin
          cmd.wr = 1'b1;
        end else begin
          cmd.clr_ref = 1'b1;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      launch_r.key <= KW'(in_tdata);
    end
    launch_r.found <= 1'b0;
    launch_r.idx   <= '0;
    if (!rst_n) begin
      state_r        <= S_IDLE;
      cap_r          <= CAP_W'(SLOTS);
      fill_r         <= '0;
      hand_r         <= '0;
      launch_r.valid <= 1'b0;
      out_tvalid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      launch_r.valid <= in_acc;
      // a result loaded in the finish state reloads the output register instead
      if (out_tvalid_r && out_tready && (state_r != S_FINISH)) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            state_r <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (tail.valid) begin
            res_hit_r     <= tail.found;
            res_value_r   <= (tail.found && (mode_r == crcd_pkg::MODE_GET)) ?
                             FW'(key_r) : '0;
            res_evicted_r <= 1'b0;
            res_ekey_r    <= '0;
            if (tail.found) begin
              res_slot_r <= crcd_pkg::SLOT_W'(tail.idx);
              state_r    <= S_FINISH;
            end else if ((mode_r == crcd_pkg::MODE_PUT) && (fill_r < live_cap)) begin
              res_slot_r <= crcd_pkg::SLOT_W'(fill_r);
              fill_r     <= fill_r + CAP_W'(1);
              state_r    <= S_FINISH;
            end else if (mode_r == crcd_pkg::MODE_PUT) begin
              res_slot_r <= '0;
              // hand may sit past a shrunk capacity
              if (CAP_W'(hand_r) >= live_cap) begin
                hand_r <= '0;
              end
              state_r <= S_SWEEP;
            end else begin
              res_slot_r <= '0;
              state_r    <= S_FINISH;
            end
          end
        end
        S_SWEEP: begin
          hand_r <= hand_inc;
          if (hand_free) begin
            res_slot_r    <= crcd_pkg::SLOT_W'(hand_r);
            res_evicted_r <= occ_vec[hand_r];
            res_ekey_r    <= occ_vec[hand_r] ? FW'(keys[hand_r]) : '0;
            state_r       <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {2'b00, res_slot_r, res_ekey_r, res_evicted_r,
                             res_value_r, res_hit_r};
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r <= in_tuser;
      key_r  <= KW'(in_tdata);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CAP_W'(SLOTS))
    else $error("fill count beyond slot count");

  a_tail_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    tail.valid |-> state_r == S_SEARCH)
    else $error("probe left the row outside a lookup");

  a_no_idle_update: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr || cmd.set_ref || cmd.clr_ref) |-> state_r != S_IDLE)
    else $error("slot update while idle");

  a_accept_launch: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> launch_r.valid && state_r == S_SEARCH)
    else $error("accepted item not launched");

endmodule

`default_nettype wire

>>> src/crcd_cell.sv
// One directory slot: key, occupied and reference bits, plus one stage of
// the lookup probe chain. Depends on crcd_pkg.
`default_nettype none

module crcd_cell (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire  [crcd_pkg::IDX_W-1:0]    slot_id,
  input  crcd_pkg::crcd_probe_t         probe_in,
  output crcd_pkg::crcd_probe_t         probe_out,
  input  crcd_pkg::crcd_cmd_t           cmd,
  output logic                          occ,
  output logic                          refb,
  output logic [crcd_pkg::KEY_BITS-1:0] key
);

  logic                          occ_r;
  logic                          ref_r;
  logic [crcd_pkg::KEY_BITS-1:0] key_r;
  crcd_pkg::crcd_probe_t         probe_r;
  crcd_pkg::crcd_probe_t         probe_nxt;
  logic                          sel;
  logic                          match;

  assign sel   = (cmd.idx == slot_id);
  // first occupied match along the row wins
  assign match = probe_in.valid & ~probe_in.found & occ_r & (key_r == probe_in.key);

  always_comb begin
    probe_nxt       = probe_in;
    probe_nxt.found = probe_in.found | match;
    if (match) begin
      probe_nxt.idx = slot_id;
    end
  end

  always_ff @(posedge clk) begin
    probe_r.found <= probe_nxt.found;
    probe_r.idx   <= probe_nxt.idx;
    probe_r.key   <= probe_nxt.key;
    if (!rst_n) begin
      occ_r         <= 1'b0;
      ref_r         <= 1'b0;
      probe_r.valid <= 1'b0;
    end else begin
      probe_r.valid <= probe_nxt.valid;
      if (sel && cmd.wr) begin
        occ_r <= 1'b1;
        ref_r <= 1'b1;
      end else if (sel && cmd.set_ref) begin
        ref_r <= 1'b1;
      end else if (sel && cmd.clr_ref) begin
        ref_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sel && cmd.wr) begin
      key_r <= cmd.key;
    end
  end

  assign probe_out = probe_r;
  assign occ       = occ_r;
  assign refb      = ref_r;
  assign key       = key_r;

endmodule

`default_nettype wire

>>> tb/clock_replacement_cache_dir_tb.sv
// Self-checking bench for the clock (second-chance) key directory.
// Needs crcd_pkg and clock_replacement_cache_dir; a scoreboard class predicts
// each result from its own copy of the directory state and checks the stream.
`timescale 1ns / 1ps

module clock_replacement_cache_dir_tb;

  localparam int   SLOTS = crcd_pkg::SLOTS;
  localparam int   CAP_W = crcd_pkg::CAP_W;
  localparam int   OUT_W = crcd_pkg::OUT_W;
  localparam logic MODE_GET = crcd_pkg::MODE_GET;
  localparam logic MODE_PUT = crcd_pkg::MODE_PUT;
  localparam int   CYCLE_LIMIT = 400000;
  localparam int   LONG_HOLD   = 300;
  localparam int   POOL_SIZE   = 32;

  typedef struct packed {
    logic        hit;
    logic [31:0] value;
    logic        evicted;
    logic [31:0] evicted_key;
    logic [3:0]  slot;
  } dir_result_t;

  class clock_dir_scoreboard;
    logic [31:0] key_store [SLOTS];
    bit          ref_flag [SLOTS];
    bit          used_flag [SLOTS];
    int          hand;
    int          fill_count;
    int          capacity;
    dir_result_t due_results [$];
    int          errors;

    function new();
      errors = 0;
      clear_directory();
    endfunction

    function void clear_directory();
      for (int i = 0; i < SLOTS; i++) begin
        key_store[i] = '0;
        ref_flag[i]  = 1'b0;
        used_flag[i] = 1'b0;
      end
      hand       = 0;
      fill_count = 0;
      capacity   = SLOTS;
      due_results.delete();
    endfunction

    function void set_capacity(bit [CAP_W-1:0] v);
      capacity = v;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    task flag_mismatch(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    // work out the result of one accepted request and update the directory
    function void note_request(logic mode, logic [31:0] key);
      dir_result_t r;
      int          pos;
      int          cap;
      int          steps;
      int          slot;
      r    = '0;
      pos  = -1;
      slot = 0;
      cap  = (capacity == 0) ? 1 : ((capacity > SLOTS) ? SLOTS : capacity);
      for (int i = SLOTS - 1; i >= 0; i--)
        if (used_flag[i] && key_store[i] == key) pos = i;
      if (pos >= 0) begin
        ref_flag[pos] = 1'b1;
        r.hit  = 1'b1;
        r.slot = 4'(pos);
        if (mode == MODE_GET) r.value = key;
      end else if (mode == MODE_PUT) begin
        if (fill_count < cap) begin
          slot = fill_count;
          fill_count++;
        end else begin
          // hand may sit past a shrunken capacity
          if (hand >= cap) hand = 0;
          for (steps = 0; steps <= cap; steps++) begin
            if (!used_flag[hand] || !ref_flag[hand]) break;
            ref_flag[hand] = 1'b0;
            hand = (hand + 1) % cap;
          end
          slot = hand;
          if (used_flag[slot]) begin
            r.evicted     = 1'b1;
            r.evicted_key = key_store[slot];
          end
          hand = (hand + 1) % cap;
        end
        key_store[slot] = key;
        ref_flag[slot]  = 1'b1;
        used_flag[slot] = 1'b1;
        r.slot = 4'(slot);
      end
      due_results.push_back(r);
    endfunction

    task check_result(logic [OUT_W-1:0] d);
      dir_result_t e;
      if (due_results.size() == 0) begin
        flag_mismatch($sformatf("result with nothing outstanding, data %h", d));
        return;
      end
      e = due_results.pop_front();
      if (d[0] !== e.hit)
        flag_mismatch($sformatf("hit %b, want %b", d[0], e.hit));
      if (d[32:1] !== e.value)
        flag_mismatch($sformatf("value %h, want %h", d[32:1], e.value));
      if (d[33] !== e.evicted)
        flag_mismatch($sformatf("evicted %b, want %b", d[33], e.evicted));
      if (d[65:34] !== e.evicted_key)
        flag_mismatch($sformatf("evicted_key %h, want %h", d[65:34], e.evicted_key));
      if (d[69:66] !== e.slot)
        flag_mismatch($sformatf("slot %0d, want %0d", d[69:66], e.slot));
    endtask
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [31:0]      in_tdata = '0;   // [31:0] key
  logic             in_tuser = 1'b0; // [0] mode
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;      // [0] hit, [32:1] value, [33] evicted,
                                    // [65:34] evicted_key, [69:66] slot
  logic             cfg_wr_en = 1'b0;
  logic [CAP_W-1:0] cfg_wr_data = '0;

  clock_dir_scoreboard sb = new();

  bit          tx_quiet = 1'b0;
  bit          rx_free = 1'b0;
  bit          long_hold_req = 1'b0;
  bit          long_hold_done = 1'b0;
  int          rx_wait = 0;
  int          cycles = 0;
  logic [31:0] key_pool [POOL_SIZE];

  clock_replacement_cache_dir uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL clock_replacement_cache_dir");
      $finish;
    end
  end

  // receiver: short random stalls, the odd long one, one very long hold-off
  always @(posedge clk) begin : rx_proc
    int unsigned r;
    r = $urandom_range(0, 99);
    if (long_hold_req && !long_hold_done) begin
      long_hold_done <= 1'b1;
      rx_wait        <= LONG_HOLD;
      out_tready     <= 1'b0;
    end else if (rx_wait != 0) begin
      rx_wait    <= rx_wait - 1;
      out_tready <= 1'b0;
    end else if (rx_free || r < 60) begin
      out_tready <= 1'b1;
    end else if (r < 95) begin
      out_tready <= 1'b0;
      rx_wait    <= $urandom_range(0, 3);
    end else begin
      out_tready <= 1'b0;
      rx_wait    <= $urandom_range(10, 60);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_request(in_tuser, in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
    end
  end

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (tx_quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // valid stays high into the next item when no gap follows
  task automatic send_item(input logic mode, input logic [31:0] key);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= key;
    do @(posedge clk); while (!in_tready);
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] v);
    in_tvalid <= 1'b0;
    // let the clock advance so the last accepted item is already on the scoreboard
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_data <= v;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_capacity(v);
  endtask

  task automatic run_phase(input logic [CAP_W-1:0] cap_setting, input int n_items);
    int          live;
    int          pool_n;
    int unsigned r;
    logic [31:0] key;
    logic        mode;
    live = (cap_setting == 0) ? 1 : ((cap_setting > SLOTS) ? SLOTS : cap_setting);
    for (int j = 0; j < POOL_SIZE; j++)
      if ($urandom_range(0, 2) == 0) key_pool[j] = $urandom;
    pool_n = live + $urandom_range(1, 6);
    if (pool_n > POOL_SIZE) pool_n = POOL_SIZE;
    for (int n = 0; n < n_items; n++) begin
      r = $urandom_range(0, 99);
      // mostly a working set just above capacity, so hits and evictions mix
      if (r < 70) key = key_pool[$urandom_range(0, pool_n - 1)];
      else if (r < 85) key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      else if (r < 95) key = $urandom;
      else key = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      mode = ($urandom_range(0, 99) < 55) ? MODE_PUT : MODE_GET;
      send_item(mode, key);
    end
  endtask

  initial begin : stimulus
    logic [CAP_W-1:0] cap_plan [10];
    cap_plan = '{5'd16, 5'd0, 5'd5, 5'd17, 5'd8, 5'd3, 5'd12, 5'd1, 5'd31, 5'd6};
    for (int j = 0; j < POOL_SIZE; j++) key_pool[j] = $urandom;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty lookup, fills, hits, touch, key extremes
    send_item(MODE_GET, 32'h0000_0000);
    send_item(MODE_PUT, 32'h0000_0000);
    send_item(MODE_PUT, 32'hFFFF_FFFF);
    send_item(MODE_GET, 32'h0000_0000);
    send_item(MODE_GET, 32'hFFFF_FFFF);
    send_item(MODE_PUT, 32'hFFFF_FFFF);
    send_item(MODE_GET, 32'h1234_5678);
    // shrink to two: full directory, all bits set, so a whole revolution
    write_capacity(5'd2);
    send_item(MODE_PUT, 32'hA5A5_A5A5);
    send_item(MODE_GET, 32'h0000_0000);
    send_item(MODE_PUT, 32'h5A5A_5A5A);
    send_item(MODE_GET, 32'hA5A5_A5A5);
    send_item(MODE_PUT, 32'h0000_0001);
    // capacity one: hand wraps, slot one lies outside but still answers
    write_capacity(5'd1);
    send_item(MODE_PUT, 32'h8000_0000);
    send_item(MODE_GET, 32'h5A5A_5A5A);
    send_item(MODE_PUT, 32'h5A5A_5A5A);
    send_item(MODE_PUT, 32'h7FFF_FFFF);
    send_item(MODE_GET, 32'h8000_0000);
    // above the slot count saturates; filling resumes after shrink
    write_capacity(5'd31);
    send_item(MODE_PUT, 32'hFEDC_BA98);
    send_item(MODE_GET, 32'hFEDC_BA98);
    send_item(MODE_GET, 32'h5A5A_5A5A);
    send_item(MODE_PUT, 32'h0123_4567);

    for (int p = 0; p < 10; p++) begin
      write_capacity(cap_plan[p]);
      tx_quiet = (p % 4 == 3);
      rx_free  = (p % 4 == 3);
      if (p == 2) long_hold_req = 1'b1;
      run_phase(cap_plan[p], 48);
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS clock_replacement_cache_dir");
    end else begin
      $display("FAIL clock_replacement_cache_dir");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/crcd_pkg.sv
src/crcd_cell.sv
src/clock_replacement_cache_dir.sv
tb/clock_replacement_cache_dir_tb.sv
